/* rtl/poht_pkg.sv */
// Package for the priority-ordered handle table.
// Holds request codes, status codes, error codes and default sizes; no dependencies.
package poht_pkg;

  localparam int unsigned MaxEntries   = 16;
  localparam int unsigned PriorityBits = 8;
  localparam int unsigned HandleW      = 16;
  localparam int unsigned ReqW         = 3;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned ErrW         = 2;

  localparam logic [ReqW-1:0] ReqInsert  = 3'd0;
  localparam logic [ReqW-1:0] ReqRemove  = 3'd1;
  localparam logic [ReqW-1:0] ReqFind    = 3'd2;
  localparam logic [ReqW-1:0] ReqActive  = 3'd3;
  localparam logic [ReqW-1:0] ReqReprio  = 3'd4;
  localparam logic [ReqW-1:0] ReqSetStat = 3'd5;
  localparam logic [ReqW-1:0] ReqCount   = 3'd6;

  localparam logic [StatusW-1:0] StStopped = 2'd0;
  localparam logic [StatusW-1:0] StPlaying = 2'd1;
  localparam logic [StatusW-1:0] StWaiting = 2'd3;

  localparam logic [ErrW-1:0] ErrNone     = 2'd0;
  localparam logic [ErrW-1:0] ErrNotFound = 2'd1;
  localparam logic [ErrW-1:0] ErrFull     = 2'd2;

endpackage

/* rtl/priority_ordered_handle_table_top.sv */
// Top level of the priority-ordered handle table.
// Depends on poht_pkg. Entries live in a memory walked one slot at a time.
// Count, unknown requests and a full insert go straight to the result; a handle search
// reads and compares each slot in turn, insert scans for its position and opens a gap,
// and reprioritize searches, closes the gap, scans for the new position and opens a gap.
// Throughput: one request at a time; in_ready_o returns the cycle after the result transfer.
// Reset: asynchronous, active low; clears the entry count and control state.
module priority_ordered_handle_table_top #(
  parameter int unsigned MAX_ENTRIES   = poht_pkg::MaxEntries,
  parameter int unsigned PRIORITY_BITS = poht_pkg::PriorityBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [poht_pkg::ReqW-1:0]        req_type_i,
  input  logic [poht_pkg::HandleW-1:0]     handle_i,
  input  logic [7:0]                       priority_req_i,
  input  logic [poht_pkg::StatusW-1:0]     new_status_i,
  input  logic                             last_valid_i,
  input  logic [poht_pkg::HandleW-1:0]     last_handle_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             found_o,
  output logic [poht_pkg::HandleW-1:0]     result_handle_o,
  output logic [7:0]                       result_priority_o,
  output logic [poht_pkg::StatusW-1:0]     result_status_o,
  output logic [4:0]                       entry_total_o,
  output logic [poht_pkg::ErrW-1:0]        error_code_o
);

  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned PW   = PRIORITY_BITS;
  localparam int unsigned EW   = poht_pkg::HandleW + PW + poht_pkg::StatusW;

  // Sequencer states.
  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SSearch  = 4'd1;  // read slot idx_q
  localparam logic [3:0] SCheck   = 4'd2;  // compare read data
  localparam logic [3:0] SActScan = 4'd3;  // fallback scan for find active
  localparam logic [3:0] SActChk  = 4'd4;
  localparam logic [3:0] SDrop    = 4'd5;  // read slot i+1
  localparam logic [3:0] SDropWr  = 4'd6;  // write slot i
  localparam logic [3:0] SPlScan  = 4'd7;  // read slot for insert position
  localparam logic [3:0] SPlChk   = 4'd8;
  localparam logic [3:0] SOpen    = 4'd9;  // read slot i-1
  localparam logic [3:0] SOpenWr  = 4'd10; // write slot i
  localparam logic [3:0] SPut     = 4'd11; // write new entry
  localparam logic [3:0] SOut     = 4'd12;

  logic [3:0]   state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;   // walking position
  logic [CntW-1:0] pos_q, pos_d;   // located entry / insert spot
  logic [poht_pkg::ReqW-1:0] req_q;
  logic [poht_pkg::HandleW-1:0] h_q, h_d;
  logic [PW-1:0] pr_q;
  logic [poht_pkg::StatusW-1:0] ns_q, s_q, s_d;
  logic last_phase_q, last_phase_d;

  // Result registers.
  logic found_q, found_d;
  logic [poht_pkg::HandleW-1:0] rh_q, rh_d;
  logic [PW-1:0] rp_q, rp_d;
  logic [poht_pkg::StatusW-1:0] rs_q, rs_d;
  logic [poht_pkg::ErrW-1:0] err_q, err_d;

  // Entry memory: one read and one write port, registered read data.
  logic [EW-1:0] mem_q [MAX_ENTRIES];
  logic [EW-1:0] rdata_q;
  logic [IdxW-1:0] raddr, waddr;
  logic we;
  logic [EW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  logic [poht_pkg::HandleW-1:0] rd_h;
  logic [PW-1:0] rd_p;
  logic [poht_pkg::StatusW-1:0] rd_s;
  assign {rd_h, rd_p, rd_s} = rdata_q;

  logic accept;
  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == SIdle);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d = idx_q;
    pos_d = pos_q;
    h_d = h_q;
    s_d = s_q;
    last_phase_d = last_phase_q;
    found_d = found_q;
    rh_d = rh_q;
    rp_d = rp_q;
    rs_d = rs_q;
    err_d = err_q;
    raddr = idx_q[IdxW-1:0];
    waddr = idx_q[IdxW-1:0];
    we = 1'b0;
    wdata = rdata_q;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          found_d = 1'b0;
          rh_d = '0;
          rp_d = '0;
          rs_d = '0;
          err_d = poht_pkg::ErrNone;
          idx_d = '0;
          h_d = handle_i;
          s_d = poht_pkg::StStopped;
          last_phase_d = 1'b0;
          unique case (req_type_i)
            poht_pkg::ReqInsert: begin
              if (count_q >= CntW'(MAX_ENTRIES)) begin
                err_d = poht_pkg::ErrFull;
                state_d = SOut;
              end else begin
                state_d = SPlScan;
              end
            end
            poht_pkg::ReqRemove, poht_pkg::ReqFind, poht_pkg::ReqReprio,
            poht_pkg::ReqSetStat: state_d = SSearch;
            poht_pkg::ReqActive: begin
              if (last_valid_i) begin
                h_d = last_handle_i;
                last_phase_d = 1'b1;
                state_d = SSearch;
              end else begin
                state_d = SActScan;
              end
            end
            poht_pkg::ReqCount: begin
              found_d = 1'b1;
              state_d = SOut;
            end
            default: state_d = SOut;
          endcase
        end
      end
      SSearch: begin
        if (idx_q >= count_q) begin
          // Handle absent.
          if (last_phase_q) begin
            idx_d = '0;
            state_d = SActScan;
          end else begin
            err_d = poht_pkg::ErrNotFound;
            state_d = SOut;
          end
        end else begin
          state_d = SCheck;
        end
      end
      SCheck: begin
        if (rd_h == h_q) begin
          pos_d = idx_q;
          rh_d = rd_h;
          rp_d = rd_p;
          rs_d = rd_s;
          unique case (req_q)
            poht_pkg::ReqActive: begin
              if (rd_s == poht_pkg::StPlaying) begin
                found_d = 1'b1;
                state_d = SOut;
              end else begin
                // Last played entry is not playing: the scan decides, fields stay clear.
                rh_d = '0;
                rp_d = '0;
                rs_d = '0;
                idx_d = '0;
                state_d = SActScan;
              end
            end
            poht_pkg::ReqFind: begin
              found_d = 1'b1;
              state_d = SOut;
            end
            poht_pkg::ReqSetStat: begin
              found_d = 1'b1;
              rs_d = ns_q;
              we = 1'b1;
              wdata = {rd_h, rd_p, ns_q};
              state_d = SOut;
            end
            default: begin
              // Remove and reprioritize close the gap first.
              found_d = 1'b1;
              s_d = rd_s;
              state_d = SDrop;
            end
          endcase
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = SSearch;
        end
      end
      SActScan: begin
        if (idx_q >= count_q) begin
          state_d = SOut;
        end else begin
          state_d = SActChk;
        end
      end
      SActChk: begin
        if (rd_s == poht_pkg::StWaiting || rd_s == poht_pkg::StPlaying) begin
          found_d = 1'b1;
          rh_d = rd_h;
          rp_d = rd_p;
          rs_d = rd_s;
          state_d = SOut;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = SActScan;
        end
      end
      SDrop: begin
        if (idx_q + 1'b1 >= count_q) begin
          count_d = count_q - 1'b1;
          if (req_q == poht_pkg::ReqReprio) begin
            idx_d = '0;
            state_d = SPlScan;
          end else begin
            state_d = SOut;
          end
        end else begin
          raddr = IdxW'(idx_q + 1'b1);
          state_d = SDropWr;
        end
      end
      SDropWr: begin
        we = 1'b1;
        idx_d = idx_q + 1'b1;
        state_d = SDrop;
      end
      SPlScan: begin
        if (idx_q >= count_q) begin
          pos_d = idx_q;
          idx_d = count_q;
          state_d = SOpen;
        end else begin
          state_d = SPlChk;
        end
      end
      SPlChk: begin
        if (rd_p > pr_q) begin
          idx_d = idx_q + 1'b1;
          state_d = SPlScan;
        end else begin
          pos_d = idx_q;
          idx_d = count_q;
          state_d = SOpen;
        end
      end
      SOpen: begin
        if (idx_q == pos_q) begin
          state_d = SPut;
        end else begin
          raddr = IdxW'(idx_q - 1'b1);
          state_d = SOpenWr;
        end
      end
      SOpenWr: begin
        we = 1'b1;
        idx_d = idx_q - 1'b1;
        state_d = SOpen;
      end
      SPut: begin
        we = 1'b1;
        waddr = pos_q[IdxW-1:0];
        wdata = {h_q, pr_q, s_q};
        count_d = count_q + 1'b1;
        found_d = 1'b1;
        rh_d = h_q;
        rp_d = pr_q;
        rs_d = s_q;
        state_d = SOut;
      end
      SOut: begin
        if (out_ready_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      last_phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      last_phase_q <= last_phase_d;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      pr_q <= PW'(priority_req_i);
      ns_q <= new_status_i;
    end
    idx_q <= idx_d;
    pos_q <= pos_d;
    h_q <= h_d;
    s_q <= s_d;
    found_q <= found_d;
    rh_q <= rh_d;
    rp_q <= rp_d;
    rs_q <= rs_d;
    err_q <= err_d;
  end

  assign out_valid_o = (state_q == SOut);
  assign found_o = found_q;
  assign result_handle_o = rh_q;
  assign result_priority_o = 8'(rp_q);
  assign result_status_o = rs_q;
  assign entry_total_o = 5'(count_q);
  assign error_code_o = err_q;

endmodule

/* rtl/poht_checker.sv */
// Port-level checker for the priority-ordered handle table.
// Depends on poht_pkg; bound to priority_ordered_handle_table_top.
module poht_props (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       found_o,
  input logic [4:0] entry_total_o,
  input logic [1:0] error_code_o
);

  // No new transfer is taken while a result is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while result pending");

  // Valid and entry total hold while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(entry_total_o))
    else $error("result dropped");

  // An error never comes with success.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != poht_pkg::ErrNone |-> !found_o)
    else $error("error with found");

  // Full error only when the table is full.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o == poht_pkg::ErrFull |-> entry_total_o == 5'd16)
    else $error("full error with room");

endmodule

bind priority_ordered_handle_table_top poht_props u_poht_props (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .found_o(found_o),
  .entry_total_o(entry_total_o), .error_code_o(error_code_o)
);

/* verif/poht_checker.sv */
// Checker for the priority-ordered handle table: watches both channels,
// keeps its own sorted entry list and compares every result transfer. Depends on poht_pkg.
`timescale 1ns / 1ps

module poht_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  req_type_i,
  input  logic [15:0] handle_i,
  input  logic [7:0]  priority_req_i,
  input  logic [1:0]  new_status_i,
  input  logic        last_valid_i,
  input  logic [15:0] last_handle_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        found_i,
  input  logic [15:0] result_handle_i,
  input  logic [7:0]  result_priority_i,
  input  logic [1:0]  result_status_i,
  input  logic [4:0]  entry_total_i,
  input  logic [1:0]  error_code_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o
);

  typedef struct packed {
    logic        found;
    logic [15:0] hnd;
    logic [7:0]  prio;
    logic [1:0]  status;
    logic [4:0]  total;
    logic [1:0]  err;
  } reply_t;

  typedef struct packed {
    logic [15:0] hnd;
    logic [7:0]  prio;
    logic [1:0]  status;
  } entry_t;

  entry_t table_q[$];
  reply_t expected_replies[$];

  // Position of the first entry holding a handle, or -1.
  function automatic int locate(logic [15:0] h);
    for (int i = 0; i < table_q.size(); i++)
      if (table_q[i].hnd == h) return i;
    return -1;
  endfunction

  // Sorted placement: after every entry of strictly greater priority.
  function automatic int place_entry(entry_t e);
    int pos;
    pos = 0;
    while (pos < table_q.size() && table_q[pos].prio > e.prio) pos++;
    table_q.insert(pos, e);
    return pos;
  endfunction

  function automatic reply_t serve_request(logic [2:0] req, logic [15:0] h, logic [7:0] p,
                                           logic [1:0] ns, logic lv, logic [15:0] lh);
    reply_t r;
    entry_t e;
    int idx;
    r = '0;
    idx = -1;
    case (req)
      poht_pkg::ReqInsert: begin
        if (table_q.size() >= poht_pkg::MaxEntries) begin
          r.err = poht_pkg::ErrFull;
        end else begin
          e = '{hnd: h, prio: p, status: poht_pkg::StStopped};
          void'(place_entry(e));
          r.found = 1'b1; r.hnd = h; r.prio = p;
        end
      end
      poht_pkg::ReqRemove, poht_pkg::ReqFind, poht_pkg::ReqReprio,
      poht_pkg::ReqSetStat: begin
        idx = locate(h);
        if (idx < 0) begin
          r.err = poht_pkg::ErrNotFound;
        end else begin
          e = table_q[idx];
          if (req == poht_pkg::ReqRemove) begin
            table_q.delete(idx);
          end else if (req == poht_pkg::ReqReprio) begin
            table_q.delete(idx);
            e.prio = p;
            void'(place_entry(e));
          end else if (req == poht_pkg::ReqSetStat) begin
            e.status = ns;
            table_q[idx] = e;
          end
          r.found = 1'b1; r.hnd = e.hnd; r.prio = e.prio; r.status = e.status;
        end
      end
      poht_pkg::ReqActive: begin
        if (lv) begin
          idx = locate(lh);
          if (idx >= 0 && table_q[idx].status != poht_pkg::StPlaying) idx = -1;
        end
        if (idx < 0)
          for (int i = 0; i < table_q.size(); i++)
            if (table_q[i].status == poht_pkg::StWaiting ||
                table_q[i].status == poht_pkg::StPlaying) begin
              idx = i;
              break;
            end
        if (idx >= 0) begin
          r.found = 1'b1; r.hnd = table_q[idx].hnd;
          r.prio = table_q[idx].prio; r.status = table_q[idx].status;
        end
      end
      poht_pkg::ReqCount: r.found = 1'b1;
      default: ;
    endcase
    r.total = 5'(table_q.size());
    return r;
  endfunction

  // Predict on each input transfer, compare on each output transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t got, want;
    if (!rst_ni) begin
      table_q.delete();
      expected_replies.delete();
      fail_count_o <= 0;
      result_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        expected_replies.push_back(serve_request(req_type_i, handle_i, priority_req_i,
                                                 new_status_i, last_valid_i, last_handle_i));
      if (out_valid_i && out_ready_i) begin
        result_count_o <= result_count_o + 1;
        got = '{found: found_i, hnd: result_handle_i, prio: result_priority_i,
                status: result_status_i, total: entry_total_i, err: error_code_i};
        if (expected_replies.size() == 0) begin
          if (fail_count_o < 10) $display("checker: result with nothing expected: %p", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10) $display("checker: mismatch expected %p got %p", want, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= expected_replies.size();
    end
  end

endmodule

/* verif/testbench.sv */
// Top of the handle table testbench: clock, reset, request stimulus and verdict.
// Depends on poht_pkg, priority_ordered_handle_table_top and poht_checker.
`timescale 1ns / 1ps

module testbench;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0;
  logic [2:0] req_type = '0;
  logic [15:0] handle = '0, last_handle = '0;
  logic [7:0] priority_req = '0;
  logic [1:0] new_status = '0;
  logic last_valid = 1'b0;
  logic found;
  logic [15:0] result_handle;
  logic [7:0] result_priority;
  logic [1:0] result_status, error_code;
  logic [4:0] entry_total;
  int fail_count, pending, result_count;
  int send_idle_pct = 24, recv_idle_pct = 53;
  bit hold_off = 1'b0;
  int cycle_count = 0;
  int item_count = 0;
  logic [15:0] live_handles[$];

  always #5 clk_i = ~clk_i;

  priority_ordered_handle_table_top dut (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(req_type), .handle_i(handle), .priority_req_i(priority_req),
    .new_status_i(new_status), .last_valid_i(last_valid), .last_handle_i(last_handle),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .found_o(found),
    .result_handle_o(result_handle), .result_priority_o(result_priority),
    .result_status_o(result_status), .entry_total_o(entry_total),
    .error_code_o(error_code)
  );

  poht_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_i(in_ready),
    .req_type_i(req_type), .handle_i(handle), .priority_req_i(priority_req),
    .new_status_i(new_status), .last_valid_i(last_valid), .last_handle_i(last_handle),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .found_i(found),
    .result_handle_i(result_handle), .result_priority_i(result_priority),
    .result_status_i(result_status), .entry_total_i(entry_total),
    .error_code_i(error_code), .fail_count_o(fail_count), .pending_o(pending),
    .result_count_o(result_count)
  );

  // Receiver: random stalls unless a long hold-off is in force.
  always @(posedge clk_i) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Offer one request and hold it until the transfer, after an optional idle gap.
  // Valid stays high after a transfer until the next request or an idle cycle replaces it.
  task automatic send_request(logic [2:0] rq, logic [15:0] h, logic [7:0] p,
                              logic [1:0] ns, logic lv, logic [15:0] lh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= rq; handle <= h; priority_req <= p;
    new_status <= ns; last_valid <= lv; last_handle <= lh;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    item_count++;
  endtask

  // Mostly handles in use, sometimes random ones; few handles make duplicates likely.
  function automatic logic [15:0] pick_handle();
    if (live_handles.size() > 0 && $urandom_range(99) < 75)
      return live_handles[$urandom_range(live_handles.size() - 1)];
    return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
  endfunction

  task automatic random_request();
    logic [2:0] rq;
    logic [15:0] h;
    h = pick_handle();
    case ($urandom_range(19))
      0, 1, 2, 3, 4: rq = poht_pkg::ReqInsert;
      5, 6, 7:       rq = poht_pkg::ReqRemove;
      8, 9:          rq = poht_pkg::ReqFind;
      10, 11, 12:    rq = poht_pkg::ReqActive;
      13, 14:        rq = poht_pkg::ReqReprio;
      15, 16, 17:    rq = poht_pkg::ReqSetStat;
      18:            rq = poht_pkg::ReqCount;
      default:       rq = 3'($urandom_range(7));
    endcase
    if (rq == poht_pkg::ReqInsert) live_handles.push_back(h);
    send_request(rq, h, 8'($urandom), 2'($urandom), 1'($urandom), pick_handle());
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-table cases, extremes, head insert, full table, every request.
    send_request(poht_pkg::ReqCount, 16'h0, 8'h0, poht_pkg::StStopped, 1'b0, 16'h0);
    send_request(poht_pkg::ReqFind, 16'hFFFF, 8'h0, poht_pkg::StStopped, 1'b0, 16'h0);
    send_request(poht_pkg::ReqActive, 16'h0, 8'h0, poht_pkg::StStopped, 1'b1, 16'hFFFF);
    send_request(poht_pkg::ReqInsert, 16'h0000, 8'h00, poht_pkg::StStopped, 1'b0, 16'h0);
    send_request(poht_pkg::ReqInsert, 16'hFFFF, 8'hFF, poht_pkg::StStopped, 1'b0, 16'h0);
    send_request(poht_pkg::ReqInsert, 16'h5555, 8'hFF, poht_pkg::StStopped, 1'b0, 16'h0);
    send_request(poht_pkg::ReqInsert, 16'hAAAA, 8'h00, poht_pkg::StStopped, 1'b0, 16'h0);
    send_request(poht_pkg::ReqActive, 16'h0, 8'h0, poht_pkg::StStopped, 1'b0, 16'h0);
    send_request(poht_pkg::ReqSetStat, 16'hAAAA, 8'h0, poht_pkg::StWaiting, 1'b0, 16'h0);
    send_request(poht_pkg::ReqSetStat, 16'h0000, 8'h0, poht_pkg::StPlaying, 1'b0, 16'h0);
    send_request(poht_pkg::ReqActive, 16'h0, 8'h0, poht_pkg::StStopped, 1'b1, 16'h0000);
    send_request(poht_pkg::ReqActive, 16'h0, 8'h0, poht_pkg::StStopped, 1'b1, 16'hAAAA);
    send_request(poht_pkg::ReqReprio, 16'hAAAA, 8'hFF, poht_pkg::StStopped, 1'b0, 16'h0);
    send_request(poht_pkg::ReqRemove, 16'h1234, 8'h0, poht_pkg::StStopped, 1'b0, 16'h0);
    send_request(poht_pkg::ReqRemove, 16'hAAAA, 8'h0, poht_pkg::StStopped, 1'b0, 16'h0);
    for (int i = 0; i < 14; i++)
      send_request(poht_pkg::ReqInsert, 16'h0007, 8'($urandom), poht_pkg::StStopped,
                   1'b0, 16'h0);
    send_request(poht_pkg::ReqInsert, 16'h0008, 8'h80, poht_pkg::StStopped, 1'b0, 16'h0);
    send_request(3'd7, 16'h0, 8'h0, poht_pkg::StStopped, 1'b0, 16'h0);
    for (int i = 0; i < 16; i++)
      send_request(poht_pkg::ReqRemove, 16'h0007, 8'h0, poht_pkg::StStopped, 1'b0, 16'h0);
    send_request(poht_pkg::ReqCount, 16'h0, 8'h0, poht_pkg::StStopped, 1'b0, 16'h0);

    // Long receiver hold-off while requests keep coming, so the block backs up.
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      repeat (10) random_request();
    join
    // Sender pauses until every result is back.
    drain();

    // Three idling phases of random traffic.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 53 : 0;
      recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 24 : 0;
      for (int i = 0; i < 270; i++) begin
        random_request();
        if (live_handles.size() > 24) live_handles.delete(0);
      end
    end

    drain();
    repeat (80) @(posedge clk_i);
    $display("testbench: %0d requests sent, %0d results checked, all request types,",
             item_count, result_count);
    $display("testbench: full and empty table, duplicates and back-pressure covered");
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
